// ===== design/b64u_pkg.sv =====
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types and the character map for the base64url encoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Index of the last character of a group
  localparam logic [1:0] LastIdxOne   = 2'd1;  // one byte: two characters
  localparam logic [1:0] LastIdxTwo   = 2'd2;  // two bytes: three characters
  localparam logic [1:0] LastIdxThree = 2'd3;  // full group: four characters

  // One group of up to three bytes, left aligned, waiting for serialization
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  last_idx;
    logic        fin;
  } b64u_grp_t;

  typedef struct packed {
    logic      push;
    b64u_grp_t grp;
  } b64u_push_t;

  // Map a 6-bit value to its URL-safe character
  function automatic logic [7:0] b64u_char(input logic [5:0] sextet);
    logic [7:0] s;
    logic [7:0] c;
    s = {2'b00, sextet};
    if (sextet < 6'd26) begin
      c = 8'h41 + s;
    end else if (sextet < 6'd52) begin
      c = 8'h61 + s - 8'd26;
    end else if (sextet < 6'd62) begin
      c = 8'h30 + s - 8'd52;
    end else if (sextet == 6'd62) begin
      c = 8'h2D;
    end else begin
      c = 8'h5F;
    end
    return c;
  endfunction

endpackage

// ===== design/b64u_front.sv =====
// ----------------------------------------------------------------------------
// b64u_front
// Collects bytes into groups of three and pushes finished groups to the queue.
// ----------------------------------------------------------------------------
module b64u_front import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  input  logic       q_full,
  output b64u_push_t q_push
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    pend_nxt        = pend_r;
    cnt_nxt         = cnt_r;
    q_push.push     = 1'b0;
    q_push.grp.bits = {pend_r, in_data_byte};
    q_push.grp.last_idx = LastIdxThree;
    q_push.grp.fin  = in_end_of_message;
    if (acc) begin
      priority if (cnt_r[1]) begin
        q_push.push = 1'b1;
        pend_nxt    = '0;
        cnt_nxt     = '0;
      end else if (in_end_of_message) begin
        q_push.push = 1'b1;
        if (cnt_r[0]) begin
          q_push.grp.bits     = {pend_r[7:0], in_data_byte, 8'h00};
          q_push.grp.last_idx = LastIdxTwo;
        end else begin
          q_push.grp.bits     = {in_data_byte, 16'h0000};
          q_push.grp.last_idx = LastIdxOne;
        end
        pend_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        pend_nxt = {pend_r[7:0], in_data_byte};
        cnt_nxt  = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== design/b64u_queue.sv =====
// ----------------------------------------------------------------------------
// b64u_queue
// Short FIFO of byte groups between the front and the back.
// ----------------------------------------------------------------------------
module b64u_queue import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  b64u_push_t q_push,
  input  logic       q_pop,
  output logic       q_full,
  output logic       q_empty,
  output b64u_grp_t  q_head
);

  b64u_grp_t            mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QueueCntW-1:0] cnt_r;
  logic                 do_pop;

  assign q_full  = (cnt_r == QueueCntW'(QueueDepth));
  assign q_empty = (cnt_r == '0);
  assign q_head  = mem[rd_ptr_r];
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem[wr_ptr_r] <= q_push.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QueueCntW'(q_push.push) - QueueCntW'(do_pop);
    end
  end

endmodule

// ===== design/b64u_back.sv =====
// ----------------------------------------------------------------------------
// b64u_back
// Serializes one group into characters through a registered output stage.
// ----------------------------------------------------------------------------
module b64u_back import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  b64u_grp_t  q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_code_char,
  output logic       out_final_char
);

  logic        busy_r, busy_nxt;
  b64u_grp_t   grp_r, grp_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        ovld_r, ovld_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        fin_r, fin_nxt;
  logic        out_free;
  logic        at_last;
  logic [5:0]  sextet;

  assign out_free = !ovld_r || !out_stall;
  assign at_last  = (idx_r == grp_r.last_idx);
  assign q_pop    = !q_empty && (!busy_r || (out_free && at_last));

  always_comb begin
    unique case (idx_r)
      2'd0:    sextet = grp_r.bits[23:18];
      2'd1:    sextet = grp_r.bits[17:12];
      2'd2:    sextet = grp_r.bits[11:6];
      default: sextet = grp_r.bits[5:0];
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    grp_nxt  = grp_r;
    idx_nxt  = idx_r;
    ovld_nxt = ovld_r && out_stall;
    char_nxt = char_r;
    fin_nxt  = fin_r;
    if (busy_r && out_free) begin
      ovld_nxt = 1'b1;
      char_nxt = b64u_char(sextet);
      fin_nxt  = grp_r.fin && at_last;
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    // load the next group as the current one drains
    if (q_pop) begin
      busy_nxt = 1'b1;
      grp_nxt  = q_head;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ovld_r <= ovld_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    char_r <= char_nxt;
    fin_r  <= fin_nxt;
  end

  assign out_valid      = ovld_r;
  assign out_code_char  = char_r;
  assign out_final_char = fin_r;

endmodule

// ===== design/base64url_encoder.sv =====
// A request that closes a group passes through the queue entry, the group register
// and the output register before its first character shows. The serializer gives
// one character per cycle while out_stall is low; three bytes give four characters.
// A two-entry group queue lets bursts of bytes enter one per cycle until it is full.
// Reset: synchronous, active low; clears pending bytes, the queue and the output.
// ----------------------------------------------------------------------------
// base64url_encoder
// Unpadded URL-safe Base64 encoder of a byte stream.
// ----------------------------------------------------------------------------
module base64url_encoder import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_code_char,
  output logic       out_final_char
);

  b64u_push_t q_push;
  b64u_grp_t  q_head;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;

  b64u_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .q_full            (q_full),
    .q_push            (q_push)
  );

  b64u_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  b64u_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_char  (out_code_char),
    .out_final_char (out_final_char)
  );

endmodule

// ===== design/b64u_checker.sv =====
// ----------------------------------------------------------------------------
// b64u_checker
// Port-level checks of the base64url encoder.
// ----------------------------------------------------------------------------
module b64u_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_data_byte,
  input logic       in_end_of_message,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_code_char,
  input logic       out_final_char
);

  logic legal_char;
  assign legal_char = (out_code_char >= 8'h41 && out_code_char <= 8'h5A) ||
                      (out_code_char >= 8'h61 && out_code_char <= 8'h7A) ||
                      (out_code_char >= 8'h30 && out_code_char <= 8'h39) ||
                      (out_code_char == 8'h2D) || (out_code_char == 8'h5F);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) &&
      $stable(in_end_of_message))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_char) &&
      $stable(out_final_char))
    else $error("stalled result changed");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> legal_char)
    else $error("character outside the URL-safe alphabet");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_early_out: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_valid)
    else $error("result before any byte was taken");

endmodule

bind base64url_encoder b64u_checker u_b64u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_data_byte      (in_data_byte),
  .in_end_of_message (in_end_of_message),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_code_char     (out_code_char),
  .out_final_char    (out_final_char)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte messages into the base64url encoder and checks every character.
// Each accepted request feeds a predictor that holds the pending bytes and
// queues the characters owed. Each accepted character is compared with the
// oldest owed one. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IdleLimit    = 1000;
  localparam int RandomItems  = 200;
  localparam int DrainCycles  = 10;

  typedef struct {
    logic [7:0] code;
    logic       fin;
  } enc_char_t;

  class char_scoreboard;
    bit [15:0]  held_bytes;
    bit [1:0]   held_count;
    enc_char_t  owed_chars[$];
    int         mismatches;
    int         checked;
    string      url_chars;

    function new();
      url_chars  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
      held_bytes = '0;
      held_count = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    // Queue the first n sextets of a left-aligned 24-bit group
    function void owe_group(bit [23:0] grp, int n, bit fin);
      enc_char_t c;
      int        sextet;
      for (int k = 0; k < n; k++) begin
        sextet = (grp >> (18 - 6 * k)) & 63;
        c.code = url_chars[sextet];
        c.fin  = fin && (k == n - 1);
        owed_chars.push_back(c);
      end
    endfunction

    function void note_request(bit [7:0] data, bit eom);
      if (held_count >= 2) begin
        owe_group({held_bytes, data}, 4, eom);
        held_bytes = '0;
        held_count = '0;
      end else if (eom) begin
        if (held_count == 0) begin
          owe_group({data, 16'h0000}, 2, 1'b1);
        end else begin
          owe_group({held_bytes[7:0], data, 8'h00}, 3, 1'b1);
        end
        held_bytes = '0;
        held_count = '0;
      end else begin
        held_bytes = {held_bytes[7:0], data};
        held_count = held_count + 2'd1;
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endfunction

    function void check_char(logic [7:0] code, logic fin);
      enc_char_t exp_c;
      checked++;
      if (owed_chars.size() == 0) begin
        report($sformatf("unexpected character code=%02h final=%0b", code, fin));
      end else begin
        exp_c = owed_chars.pop_front();
        if (code !== exp_c.code || fin !== exp_c.fin) begin
          report($sformatf("expected code=%02h final=%0b, got code=%02h final=%0b",
                           exp_c.code, exp_c.fin, code, fin));
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_end_of_message;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_code_char;
  logic       out_final_char;

  char_scoreboard sb;
  logic [7:0]     msg_q[$];
  int             bytes_sent;
  int             msgs_sent;
  int             idle_cycles;

  base64url_encoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code_char     (out_code_char),
    .out_final_char    (out_final_char)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic send_req(input logic [7:0] data, input logic eom, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    sb.note_request(data, eom);
    bytes_sent++;
  endtask

  // Send msg_q as one message, end mark on its last byte
  task automatic send_msg(input bit burst);
    for (int i = 0; i < msg_q.size(); i++) begin
      send_req(msg_q[i], i == msg_q.size() - 1, burst ? 0 : pick_gap());
    end
    msgs_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.owed_chars.size() != 0) @(posedge clk);
  endtask

  // Result side: runs of open cycles broken by stalls, mostly short
  initial begin
    int run_len;
    int stall_len;
    out_stall = 1'b0;
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                            : $urandom_range(0, 20);
      stall_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                             : $urandom_range(10, 40);
      repeat (run_len) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat (stall_len) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_char(out_code_char, out_final_char);
    end
  end

  // Watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, IdleLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int r;
    bit burst;
    int target;
    sb                = new();
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = 8'h00;
    in_end_of_message = 1'b0;
    bytes_sent        = 0;
    msgs_sent         = 0;
    idle_cycles       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one and two leftover bytes, full groups, '-' and '_', all-ones
    msg_q = '{8'h00};
    send_msg(1'b0);
    msg_q = '{8'hFF, 8'hFF};
    send_msg(1'b0);
    msg_q = '{8'hFB, 8'hEF, 8'hBE};
    send_msg(1'b1);
    msg_q = '{8'hFF, 8'hFF, 8'hFF};
    send_msg(1'b0);
    msg_q = '{8'h00, 8'h10, 8'h83, 8'hFF};
    send_msg(1'b1);
    msg_q = '{8'h01, 8'h80, 8'h7F, 8'hFE, 8'h40};
    send_msg(1'b0);
    msg_q = '{8'hFF};
    send_msg(1'b1);
    msg_q = '{8'h4D, 8'h61, 8'h6E, 8'h2D, 8'h5F, 8'h00};
    send_msg(1'b0);
    wait_drained();

    target = RandomItems;
    while (bytes_sent < target) begin
      r   = $urandom_range(0, 99);
      len = (r < 10) ? $urandom_range(20, 30) : $urandom_range(1, 9);
      burst = ($urandom_range(0, 9) < 3);
      msg_q.delete();
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          msg_q.push_back(8'h00);
        end else if (r < 20) begin
          msg_q.push_back(8'hFF);
        end else begin
          msg_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_msg(burst);
      // hold off until the encoder has emptied once mid-run
      if (msgs_sent == 20) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d messages (%0d bytes); checked %0d characters in order.",
             msgs_sent, bytes_sent, sb.checked);
    $display("Mismatches: %0d, characters still owed: %0d",
             sb.mismatches, sb.owed_chars.size());
    if (sb.mismatches == 0 && sb.owed_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/b64u_pkg.sv
design/b64u_front.sv
design/b64u_queue.sv
design/b64u_back.sv
design/base64url_encoder.sv
design/b64u_checker.sv
tb/sv/tb_top.sv
